// File: rtl/core/fpsrs_pkg.sv
// Package for the Fenwick point-set / range-sum core: field widths, operation
// codes, register map and the command/status structs between control and datapath.
// No dependencies.
`default_nettype none

package fpsrs_pkg;

   // Item field widths
   localparam int OP_W   = 2;
   localparam int POS_W  = 11;
   localparam int DATA_W = 64;
   localparam int SIZE_W = 11;

   // Operation codes (code 3 is ignored by the core)
   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_SET   = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   // Configuration register map
   localparam int                CSR_DATA_W   = 32;
   localparam int                CSR_ADDR_W   = 3;
   localparam logic              CSR_IDX_SIZE = 1'b0;
   localparam logic [SIZE_W-1:0] SIZE_RESET   = 11'd1024;

   // Walk start point selects
   localparam logic [1:0] WSEL_POS     = 2'd0;
   localparam logic [1:0] WSEL_POS_M1  = 2'd1;
   localparam logic [1:0] WSEL_RIGHT   = 2'd2;
   localparam logic [1:0] WSEL_LEFT_M1 = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic       clear_step;
      logic       latch_item;
      logic       load_walk;
      logic [1:0] walk_sel;
      logic       clear_acc;
      logic       prefix_step;
      logic       prefix_sub;
      logic       upd_read;
      logic       upd_write;
      logic       load_delta_value;
      logic       load_delta_diff;
      logic       push_result;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic is_add;
      logic is_set;
      logic is_query;
      logic query_empty;
      logic prefix_done;
      logic upd_active;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/core/fpsrs_req_if.sv
// Input item channel: valid/ready handshake with the operation payload.
// Depends on fpsrs_pkg.
`default_nettype none

interface fpsrs_req_if;
   import fpsrs_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic [POS_W-1:0]         position;
   logic [POS_W-1:0]         range_left;
   logic [POS_W-1:0]         range_right;
   logic signed [DATA_W-1:0] value;

   modport source (
      output valid, operation, position, range_left, range_right, value,
      input  ready
   );

   modport sink (
      input  valid, operation, position, range_left, range_right, value,
      output ready
   );

endinterface

`default_nettype wire

// File: rtl/core/fpsrs_rsp_if.sv
// Result item channel: valid/ready handshake carrying the range sum.
// Depends on fpsrs_pkg.
`default_nettype none

interface fpsrs_rsp_if;
   import fpsrs_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] range_sum;

   modport source (
      output valid, range_sum,
      input  ready
   );

   modport sink (
      input  valid, range_sum,
      output ready
   );

endinterface

`default_nettype wire

// File: rtl/core/fpsrs_ctrl.sv
// Controller state machine: sequences clearing, prefix walks and update walks.
// Depends on fpsrs_pkg; drives fpsrs_dpath through cmd_type / status_type.
`default_nettype none

module fpsrs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire fpsrs_pkg::status_type st,
   output fpsrs_pkg::cmd_type        cmd
);
   import fpsrs_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DECODE = 3'd2;
   localparam logic [2:0] ST_PRE_A  = 3'd3;
   localparam logic [2:0] ST_PRE_B  = 3'd4;
   localparam logic [2:0] ST_UPD_RD = 3'd5;
   localparam logic [2:0] ST_UPD_WR = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and command decode
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (st.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.latch_item = req_valid;
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if (st.is_add) begin
               cmd.load_walk        = 1'b1;
               cmd.walk_sel         = WSEL_POS;
               cmd.load_delta_value = 1'b1;
               state_in             = ST_UPD_RD;
            end else if (st.is_set) begin
               cmd.load_walk = 1'b1;
               cmd.walk_sel  = WSEL_POS;
               cmd.clear_acc = 1'b1;
               state_in      = ST_PRE_A;
            end else if (st.is_query && !st.query_empty) begin
               cmd.load_walk = 1'b1;
               cmd.walk_sel  = WSEL_RIGHT;
               cmd.clear_acc = 1'b1;
               state_in      = ST_PRE_A;
            end else if (st.is_query) begin
               // empty range: report zero
               cmd.clear_acc = 1'b1;
               state_in      = ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PRE_A: begin
            // first prefix walk adds its nodes
            cmd.prefix_step = 1'b1;
            if (st.prefix_done) begin
               cmd.load_walk = 1'b1;
               cmd.walk_sel  = st.is_set ? WSEL_POS_M1 : WSEL_LEFT_M1;
               state_in      = ST_PRE_B;
            end
         end
         ST_PRE_B: begin
            // second prefix walk subtracts
            cmd.prefix_step = 1'b1;
            cmd.prefix_sub  = 1'b1;
            if (st.prefix_done) begin
               if (st.is_set) begin
                  cmd.load_delta_diff = 1'b1;
                  cmd.load_walk       = 1'b1;
                  cmd.walk_sel        = WSEL_POS;
                  state_in            = ST_UPD_RD;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_UPD_RD: begin
            if (st.upd_active) begin
               cmd.upd_read = 1'b1;
               state_in     = ST_UPD_WR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_UPD_WR: begin
            cmd.upd_write = 1'b1;
            state_in      = ST_UPD_RD;
         end
         ST_OUT: begin
            if (st.out_free) begin
               cmd.push_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/fpsrs_dpath.sv
// Datapath: partial-sum memory, walk index, accumulator, delta and result register.
// Depends on fpsrs_pkg; commanded by fpsrs_ctrl.
`default_nettype none

module fpsrs_dpath #(
   parameter int MAX_POSITIONS = 1024
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire fpsrs_pkg::cmd_type                     cmd,
   output fpsrs_pkg::status_type                       st,
   input  wire logic [fpsrs_pkg::SIZE_W-1:0]           size_in_use,
   input  wire logic [fpsrs_pkg::OP_W-1:0]             req_operation,
   input  wire logic [fpsrs_pkg::POS_W-1:0]            req_position,
   input  wire logic [fpsrs_pkg::POS_W-1:0]            req_range_left,
   input  wire logic [fpsrs_pkg::POS_W-1:0]            req_range_right,
   input  wire logic signed [fpsrs_pkg::DATA_W-1:0]    req_value,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [fpsrs_pkg::DATA_W-1:0]         rsp_range_sum
);
   import fpsrs_pkg::*;

   localparam int AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
   // walk index: holds any position and one update step beyond it
   localparam int WW = (AW + 1 > POS_W + 1) ? AW + 1 : POS_W + 1;
   localparam logic [WW-1:0] MAX_W  = WW'(MAX_POSITIONS);
   localparam logic [WW-1:0] LAST_W = WW'(MAX_POSITIONS - 1);
   localparam logic [WW-1:0] ONE_W  = WW'(1);

   // Latched item
   logic [OP_W-1:0]          op_ff;
   logic [POS_W-1:0]         pos_ff;
   logic [POS_W-1:0]         left_ff;
   logic [POS_W-1:0]         right_ff;
   logic signed [DATA_W-1:0] value_ff;

   logic [WW-1:0]            walk_ff, walk_in;
   logic [DATA_W-1:0]        acc_ff, acc_in;
   logic [DATA_W-1:0]        delta_ff, delta_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic [DATA_W-1:0]        rd_data_ff;
   logic                     out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]        out_data_ff, out_data_in;
   logic [DATA_W-1:0]        psum_ff [MAX_POSITIONS];

   logic [WW-1:0]            n_w, pos_w, left_w, right_w, walk_m1, lowbit;
   logic                     walk_nz, pos_ok;
   logic                     mem_we, mem_re;
   logic [AW-1:0]            mem_wa, mem_ra;
   logic [DATA_W-1:0]        mem_wd;

   // Covered size and clamped bounds
   always_comb begin
      n_w     = ({{(WW-SIZE_W){1'b0}}, size_in_use} > MAX_W) ? MAX_W
              : {{(WW-SIZE_W){1'b0}}, size_in_use};
      pos_w   = {{(WW-POS_W){1'b0}}, pos_ff};
      left_w  = (left_ff == '0) ? ONE_W : {{(WW-POS_W){1'b0}}, left_ff};
      right_w = ({{(WW-POS_W){1'b0}}, right_ff} > n_w) ? n_w
              : {{(WW-POS_W){1'b0}}, right_ff};
      pos_ok  = (pos_ff != '0) && (pos_w <= n_w);
      walk_nz = (walk_ff != '0);
      walk_m1 = walk_ff - ONE_W;
      lowbit  = walk_ff & (~walk_ff + ONE_W);
   end

   // Status to controller
   always_comb begin
      st.clear_last  = (walk_ff == LAST_W);
      st.is_add      = (op_ff == OP_ADD) && pos_ok;
      st.is_set      = (op_ff == OP_SET) && pos_ok;
      st.is_query    = (op_ff == OP_QUERY);
      st.query_empty = (left_w > right_w);
      st.prefix_done = !walk_nz && !rd_valid_ff;
      st.upd_active  = walk_nz && (walk_ff <= n_w);
      st.out_free    = !out_valid_ff || rsp_ready;
   end

   // Walk index
   always_comb begin
      priority if (cmd.load_walk) begin
         unique case (cmd.walk_sel)
            WSEL_POS:    walk_in = pos_w;
            WSEL_POS_M1: walk_in = pos_w - ONE_W;
            WSEL_RIGHT:  walk_in = right_w;
            default:     walk_in = left_w - ONE_W;
         endcase
      end else if (cmd.clear_step) begin
         walk_in = walk_ff + ONE_W;
      end else if (cmd.prefix_step && walk_nz) begin
         walk_in = walk_ff - lowbit;
      end else if (cmd.upd_write) begin
         walk_in = walk_ff + lowbit;
      end else begin
         walk_in = walk_ff;
      end
   end

   // Memory port control
   always_comb begin
      mem_re = (cmd.prefix_step && walk_nz) || cmd.upd_read;
      mem_ra = walk_m1[AW-1:0];
      mem_we = cmd.clear_step || cmd.upd_write;
      mem_wa = cmd.clear_step ? walk_ff[AW-1:0] : walk_m1[AW-1:0];
      mem_wd = cmd.clear_step ? '0 : rd_data_ff + delta_ff;
   end

   // Accumulator, delta, result register
   always_comb begin
      rd_valid_in = cmd.prefix_step && walk_nz;

      acc_in = acc_ff;
      if (cmd.clear_acc) begin
         acc_in = '0;
      end else if (cmd.prefix_step && rd_valid_ff) begin
         acc_in = cmd.prefix_sub ? acc_ff - rd_data_ff : acc_ff + rd_data_ff;
      end

      delta_in = delta_ff;
      if (cmd.load_delta_value) begin
         delta_in = value_ff;
      end else if (cmd.load_delta_diff) begin
         delta_in = value_ff - acc_ff;
      end

      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (cmd.push_result) begin
         out_valid_in = 1'b1;
         out_data_in  = acc_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         walk_ff      <= walk_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         op_ff    <= req_operation;
         pos_ff   <= req_position;
         left_ff  <= req_range_left;
         right_ff <= req_range_right;
         value_ff <= req_value;
      end
      acc_ff      <= acc_in;
      delta_ff    <= delta_in;
      out_data_ff <= out_data_in;
   end

   // Partial-sum memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         psum_ff[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= psum_ff[mem_ra];
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_range_sum = out_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/fenwick_point_set_range_sum_core.sv
// Top level of the Fenwick point-set / range-sum core: APB size register,
// controller and datapath. Depends on fpsrs_pkg, fpsrs_req_if, fpsrs_rsp_if,
// fpsrs_ctrl and fpsrs_dpath.
`default_nettype none

// Binary indexed tree of 64-bit wrapping sums over positions 1..n, where n is the
// size register clamped to MAX_POSITIONS. Items are add, set or range query; only
// a query returns a result item. After reset the core runs a clearing pass over
// every word of the partial-sum memory before it takes its first item.
// One item is in work at a time. The partial-sum memory has one write port and one
// registered read port: a prefix walk reads one node per step and adds or subtracts
// it once the registered read returns; an update walk reads each node, then writes
// it back with the delta added, and ends with a closing check. A set runs a prefix
// walk to pos and one to pos-1 before its update walk; a query runs prefix walks to
// right and to left-1; an add runs only the update walk. An empty query reports zero
// with no walk, and an ignored item is dropped. A query also waits while the previous
// result item is still unaccepted; a finished result waits in an output register
// while the next item is taken.
module fenwick_point_set_range_sum_core #(
   parameter int MAX_POSITIONS = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   fpsrs_req_if.sink                                req_ch,
   fpsrs_rsp_if.source                              rsp_ch,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [fpsrs_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [fpsrs_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [fpsrs_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                     pready
);
   import fpsrs_pkg::*;

   logic [SIZE_W-1:0] size_ff, size_in;
   logic              csr_wr;
   cmd_type           dp_cmd;
   status_type        dp_st;
   logic              req_ready;

   // Configuration register
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready && (paddr[2] == CSR_IDX_SIZE);

   always_comb begin
      size_in = csr_wr ? pwdata[SIZE_W-1:0] : size_ff;
      prdata  = (paddr[2] == CSR_IDX_SIZE) ? {{(CSR_DATA_W-SIZE_W){1'b0}}, size_ff} : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   fpsrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .st        (dp_st),
      .cmd       (dp_cmd)
   );

   fpsrs_dpath #(
      .MAX_POSITIONS (MAX_POSITIONS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .st              (dp_st),
      .size_in_use     (size_ff),
      .req_operation   (req_ch.operation),
      .req_position    (req_ch.position),
      .req_range_left  (req_ch.range_left),
      .req_range_right (req_ch.range_right),
      .req_value       (req_ch.value),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_range_sum   (rsp_ch.range_sum)
   );

   assign req_ch.ready = req_ready;

   // Write-back of an update node always follows its read
   a_upd_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.upd_write |-> $past(dp_cmd.upd_read))
      else $error("update write without preceding read");

   // A result is only loaded when the output register can take it
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.push_result |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result pushed over a pending item");

   // A new result item appears only after a push
   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(dp_cmd.push_result))
      else $error("result valid without push");

   // No item taken while the memory is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.clear_step |-> !req_ready)
      else $error("item accepted during clearing pass");

endmodule

`default_nettype wire

// File: bench/fpsrs_range_sum_checker.sv
// Passive checker for the Fenwick point-set / range-sum core: snoops the size
// register writes, keeps its own tree of partial sums and checks every range sum.
// Depends on fpsrs_pkg, fpsrs_req_if and fpsrs_rsp_if.
`default_nettype none

module fpsrs_range_sum_checker #(
   parameter int                               MAX_POSITIONS = 1024,
   parameter logic [fpsrs_pkg::CSR_ADDR_W-1:0] SIZE_ADDR     = '0
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   fpsrs_req_if                                  req_ch,
   fpsrs_rsp_if                                  rsp_ch,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic                             pready,
   input  wire logic [fpsrs_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [fpsrs_pkg::CSR_DATA_W-1:0] pwdata,
   input  wire logic [fpsrs_pkg::CSR_DATA_W-1:0] prdata,
   output int                                    mismatch_count,
   output int                                    sums_pending
);
   import fpsrs_pkg::*;

   // Shadow tree, size register and the range sums still owed by the core
   logic [DATA_W-1:0] node_sums [MAX_POSITIONS];
   logic [SIZE_W-1:0] size_reg;
   logic [DATA_W-1:0] owed_sums [$];
   int                mismatch_total = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h, want %h", what, got, want);
      mismatch_total++;
   endtask

   // Sum of positions 1..p
   function automatic logic [DATA_W-1:0] prefix_total(input int unsigned p);
      logic [DATA_W-1:0] acc = '0;
      while (p != 0) begin
         acc += node_sums[p-1];
         p   -= p & (~p + 1);
      end
      return acc;
   endfunction

   // Add delta to every node covering p, up to n
   task automatic add_walk(input int unsigned p, input int unsigned n,
                           input logic [DATA_W-1:0] delta);
      while (p != 0 && p <= n) begin
         node_sums[p-1] += delta;
         p              += p & (~p + 1);
      end
   endtask

   task automatic apply_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [POS_W-1:0] left, input logic [POS_W-1:0] right,
                             input logic [DATA_W-1:0] val);
      int unsigned       n;
      int unsigned       p;
      int unsigned       lo;
      int unsigned       hi;
      logic [DATA_W-1:0] delta;
      n = (size_reg > MAX_POSITIONS) ? MAX_POSITIONS : size_reg;
      p = pos;
      case (op)
         OP_ADD, OP_SET: begin
            // out-of-range positions leave the tree alone
            if (p != 0 && p <= n) begin
               delta = val;
               if (op == OP_SET)
                  delta = val - (prefix_total(p) - prefix_total(p - 1));
               add_walk(p, n, delta);
            end
         end
         OP_QUERY: begin
            lo = (left == 0) ? 1 : left;
            hi = (right > n) ? n : right;
            if (lo > hi)
               owed_sums.insert(owed_sums.size(), '0);
            else
               owed_sums.insert(owed_sums.size(),
                                prefix_total(hi) - prefix_total(lo - 1));
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      logic [DATA_W-1:0] want;
      if (reset) begin
         foreach (node_sums[i]) node_sums[i] = '0;
         size_reg = SIZE_RESET;
         owed_sums.delete();
      end else begin
         // register access
         if (psel && penable && pready && paddr == SIZE_ADDR) begin
            if (pwrite)
               size_reg = pwdata[SIZE_W-1:0];
            else if (prdata != CSR_DATA_W'(size_reg))
               report_mismatch("size readback", 64'(prdata), 64'(size_reg));
         end

         // result item
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (owed_sums.size() == 0) begin
               report_mismatch("range_sum with no query waiting", rsp_ch.range_sum, '0);
            end else begin
               want = owed_sums.pop_front();
               if (rsp_ch.range_sum !== want)
                  report_mismatch("range_sum", rsp_ch.range_sum, want);
            end
         end

         // input item
         if (req_ch.valid && req_ch.ready)
            apply_item(req_ch.operation, req_ch.position, req_ch.range_left,
                       req_ch.range_right, req_ch.value);
      end
      sums_pending   <= owed_sums.size();
      mismatch_count <= mismatch_total;
   end

endmodule

`default_nettype wire

// File: bench/tb_fenwick_point_set_range_sum_core.sv
// Testbench top for the Fenwick point-set / range-sum core: clock, reset, size
// register writes, item stimulus with idling, and the verdict.
// Depends on fpsrs_pkg, fpsrs_req_if, fpsrs_rsp_if and fpsrs_range_sum_checker.
`default_nettype none

module tb_fenwick_point_set_range_sum_core;
   import fpsrs_pkg::*;

   localparam int                    POSITIONS     = 1024;
   localparam logic [OP_W-1:0]       OP_IGNORED    = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] SIZE_REG_ADDR = {CSR_IDX_SIZE, 2'b00};
   localparam int                    NUM_PHASES    = 7;
   localparam int                    SETTLE_CYCLES = 64;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int mismatch_count;
   int sums_pending;
   int send_idle_pct;
   int stall_pct;

   fpsrs_req_if req_ch ();
   fpsrs_rsp_if rsp_ch ();

   fenwick_point_set_range_sum_core #(
      .MAX_POSITIONS (POSITIONS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   fpsrs_range_sum_checker #(
      .MAX_POSITIONS (POSITIONS),
      .SIZE_ADDR     (SIZE_REG_ADDR)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .mismatch_count (mismatch_count),
      .sums_pending   (sums_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop
   initial begin
      #12000000;
      $display("Regression FAIL");
      $finish;
   end

   // Result side back-pressure
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // One item on the request channel; valid stays up after acceptance
   task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [POS_W-1:0] left, input logic [POS_W-1:0] right,
                            input logic [DATA_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= op;
      req_ch.position    <= pos;
      req_ch.range_left  <= left;
      req_ch.range_right <= right;
      req_ch.value       <= val;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Sender holds off until every owed range sum is back and the core is idle
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sums_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write_en, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write_en;
      paddr   <= SIZE_REG_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly well-formed items over 1..n, with noise on every field
   task automatic send_random_item(input int unsigned n, output bit counted);
      logic [OP_W-1:0]   op;
      logic [POS_W-1:0]  pos;
      logic [POS_W-1:0]  left;
      logic [POS_W-1:0]  right;
      logic [POS_W-1:0]  a;
      logic [POS_W-1:0]  b;
      logic [DATA_W-1:0] val;
      int unsigned       pick;
      pos   = POS_W'($urandom);
      left  = POS_W'($urandom);
      right = POS_W'($urandom);
      val   = {$urandom, $urandom};
      case ($urandom_range(9))
         0:       val = {1'b1, {(DATA_W-1){1'b0}}};
         1:       val = {1'b0, {(DATA_W-1){1'b1}}};
         2:       val = '1;
         3:       val = '0;
         4, 5, 6: val = DATA_W'($urandom_range(200)) - DATA_W'(100);
         default: ;
      endcase

      pick = $urandom_range(19);
      if (pick == 0)
         op = OP_IGNORED;
      else if (pick <= 8)
         op = OP_ADD;
      else if (pick <= 13)
         op = OP_SET;
      else
         op = OP_QUERY;

      if (n != 0 && $urandom_range(9) != 0)
         pos = POS_W'($urandom_range(n, 1));

      // query bounds: ordered in-range pairs, plus zero left, overhanging right
      if (n != 0) begin
         case ($urandom_range(9))
            0: ;
            1: begin
               left  = '0;
               right = POS_W'($urandom_range(n, 1));
            end
            2: begin
               left  = POS_W'($urandom_range(n, 1));
               right = POS_W'($urandom_range((1 << POS_W) - 1, n));
            end
            default: begin
               a     = POS_W'($urandom_range(n, 1));
               b     = POS_W'($urandom_range(n, 1));
               left  = (a < b) ? a : b;
               right = (a < b) ? b : a;
            end
         endcase
      end

      counted = (op == OP_QUERY) || ((op == OP_ADD || op == OP_SET) && pos != 0 && pos <= n);
      send_item(op, pos, left, right, val);
   endtask

   initial begin
      int unsigned phase_size  [NUM_PHASES];
      int          phase_items [NUM_PHASES];
      int          phase_idle  [NUM_PHASES];
      int unsigned n;
      int          done;
      bit          counted;

      phase_size  = '{1024, 1, 0, 2047, 13, 0, 1024};
      phase_items = '{250, 50, 40, 170, 100, 170, 150};
      phase_idle  = '{0, 0, 1, 1, 1, 2, 2};
      phase_size[5] = $urandom_range(1023, 2);

      reset              <= 1'b1;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.operation   <= OP_ADD;
      req_ch.position    <= '0;
      req_ch.range_left  <= '0;
      req_ch.range_right <= '0;
      req_ch.value       <= '0;
      send_idle_pct = 34;
      stall_pct     = 87;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset size of 1024
      send_item(OP_ADD,     11'd1,    '0,       '0,       64'h7fff_ffff_ffff_ffff);
      send_item(OP_ADD,     11'd1024, '0,       '0,       64'h8000_0000_0000_0000);
      send_item(OP_ADD,     11'd512,  '0,       '0,       '1);
      send_item(OP_QUERY,   '0,       11'd1,    11'd1024, '0);
      send_item(OP_QUERY,   '0,       11'd0,    11'd2047, '0);
      send_item(OP_ADD,     11'd1,    '0,       '0,       64'd1);
      send_item(OP_SET,     11'd1,    '0,       '0,       64'd5);
      send_item(OP_SET,     11'd1024, '0,       '0,       64'h0123_4567_89ab_cdef);
      send_item(OP_QUERY,   '0,       11'd1,    11'd1,    '0);
      send_item(OP_QUERY,   '0,       11'd1024, 11'd1024, '0);
      send_item(OP_QUERY,   '0,       11'd700,  11'd300,  '0);
      send_item(OP_ADD,     11'd0,    '0,       '0,       64'd99);
      send_item(OP_ADD,     11'd1025, '0,       '0,       64'd99);
      send_item(OP_SET,     11'd2047, '0,       '0,       '1);
      send_item(OP_IGNORED, 11'd3,    11'd1,    11'd1024, 64'd1);
      send_item(OP_QUERY,   '0,       11'd2,    11'd1023, '0);
      send_item(OP_SET,     11'd512,  '0,       '0,       64'h8000_0000_0000_0000);
      send_item(OP_QUERY,   '0,       11'd511,  11'd513,  '0);
      send_item(OP_QUERY,   '0,       11'd0,    11'd0,    '0);
      send_item(OP_ADD,     11'd1023, '0,       '0,       64'd1);
      send_item(OP_QUERY,   '0,       11'd1023, 11'd1024, '0);
      send_item(OP_QUERY,   '0,       11'd2047, 11'd2047, '0);
      settle();

      // Random phases, each under its own size setting and idling pattern
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         csr_access(1'b1, CSR_DATA_W'(phase_size[ph]));
         csr_access(1'b0, '0);
         n = (phase_size[ph] > POSITIONS) ? POSITIONS : phase_size[ph];
         case (phase_idle[ph])
            0: begin
               send_idle_pct = 34;
               stall_pct     = 87;
            end
            1: begin
               send_idle_pct = 87;
               stall_pct     = 34;
            end
            default: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
         endcase
         done = 0;
         while (done < phase_items[ph]) begin
            send_random_item(n, counted);
            if (counted)
               done++;
         end
         settle();
      end

      if (mismatch_count == 0 && sums_pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
